[src/bptc_pkg.sv]
// Shared types and constants for the barometric compensation pipeline.
package bptc_pkg;

  // Field widths.
  localparam int D_W        = 24;
  localparam int CAL_W      = 16;
  localparam int DT_W       = 25;
  localparam int WIDE_W     = 40;
  localparam int TEMP_W     = 19;
  localparam int PRES_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Temperature thresholds in 0.01 degC. The quotient dT*C6/2^23 is the
  // temperature minus TEMP_REF, so the very-cold test adds VCOLD_OFS to it.
  localparam int TEMP_REF  = 2000;
  localparam int VCOLD_OFS = 3500;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_C1     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C2     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C3     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C4     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C5     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C6     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SO_EN  = 3'd6;

  // Calibration register set.
  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
    logic             second_order_enable;
  } calib_t;

  // First-order terms and second-order corrections handed to the pressure stages.
  typedef struct packed {
    logic        [D_W-1:0]    d1;
    logic signed [WIDE_W-1:0] off1;
    logic signed [WIDE_W-1:0] sens1;
    logic        [WIDE_W-1:0] off2;
    logic        [WIDE_W-1:0] sens2;
    logic signed [TEMP_W-1:0] temp;
  } corr_t;

endpackage

[src/baro_pressure_temp_compensation.sv]
// Throughput: one transaction per cycle while out_ready does not stall the output; each of
// the ten register stages holds one level of multipliers no wider than 25 by 25 bits or
// at most three dependent wide adds.
// Reset (synchronous, active high) empties the pipeline, clears the calibration
// words to zero and sets second-order compensation on.
module baro_pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bptc_pkg::D_W-1:0]            raw_pressure,
  input  logic [bptc_pkg::D_W-1:0]            raw_temperature,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bptc_pkg::PRES_W-1:0]  pressure_centimbar,
  output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centideg,
  input  logic                                write_enable,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0]     write_data
);

  bptc_pkg::calib_t calib;
  bptc_pkg::corr_t  corr;
  logic             mid_valid;
  logic             mid_ready;

  // Calibration registers.
  bptc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .calib        (calib)
  );

  // Temperature and correction stages.
  bptc_temp_path u_temp (
    .clk             (clk),
    .rst             (rst),
    .calib           (calib),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_valid       (mid_valid),
    .out_ready       (mid_ready),
    .corr            (corr)
  );

  // Pressure stages and output register.
  bptc_pres_path u_pres (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (mid_valid),
    .in_ready             (mid_ready),
    .corr                 (corr),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .pressure_centimbar   (pressure_centimbar),
    .temperature_centideg (temperature_centideg)
  );

endmodule

[src/bptc_cfg_regs.sv]
// Calibration register file written through the plain write port.
module bptc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]     reg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0]    write_data,
  output bptc_pkg::calib_t                   calib
);

  // Register writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      calib.c1 <= '0;
      calib.c2 <= '0;
      calib.c3 <= '0;
      calib.c4 <= '0;
      calib.c5 <= '0;
      calib.c6 <= '0;
      calib.second_order_enable <= 1'b1;
    end else if (write_enable) begin
      unique case (reg_index)
        bptc_pkg::REG_C1:    calib.c1 <= write_data;
        bptc_pkg::REG_C2:    calib.c2 <= write_data;
        bptc_pkg::REG_C3:    calib.c3 <= write_data;
        bptc_pkg::REG_C4:    calib.c4 <= write_data;
        bptc_pkg::REG_C5:    calib.c5 <= write_data;
        bptc_pkg::REG_C6:    calib.c6 <= write_data;
        bptc_pkg::REG_SO_EN: calib.second_order_enable <= write_data[0];
        default: ;
      endcase
    end
  end

endmodule

[src/bptc_temp_path.sv]
// Stages one to five: dT, first-order OFF and SENS, temperature, second-order terms.
module bptc_temp_path (
  input  logic                          clk,
  input  logic                          rst,
  input  bptc_pkg::calib_t              calib,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bptc_pkg::D_W-1:0]      raw_pressure,
  input  logic [bptc_pkg::D_W-1:0]      raw_temperature,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bptc_pkg::corr_t               corr
);

  localparam int N = 5;

  logic [N-1:0] v;
  logic [N-1:0] adv;

  // Stage registers.
  logic signed [bptc_pkg::DT_W-1:0]   s1_dt;
  logic        [bptc_pkg::D_W-1:0]    s1_d1;
  logic signed [41:0]                 s2_p_off;
  logic signed [41:0]                 s2_p_sens;
  logic signed [41:0]                 s2_p_t;
  logic signed [49:0]                 s2_p_dd;
  logic        [bptc_pkg::D_W-1:0]    s2_d1;
  logic signed [bptc_pkg::WIDE_W-1:0] s3_off1;
  logic signed [bptc_pkg::WIDE_W-1:0] s3_sens1;
  logic signed [bptc_pkg::TEMP_W-1:0] s3_q;
  logic signed [bptc_pkg::TEMP_W-1:0] s3_temp;
  logic signed [bptc_pkg::TEMP_W-1:0] s3_bq;
  logic        [bptc_pkg::TEMP_W-1:0] s3_dd;
  logic        [bptc_pkg::D_W-1:0]    s3_d1;
  logic signed [37:0]                 s4_sq_a;
  logic signed [37:0]                 s4_sq_b;
  logic                               s4_cold;
  logic                               s4_vcold;
  logic signed [bptc_pkg::TEMP_W-1:0] s4_temp;
  logic signed [bptc_pkg::WIDE_W-1:0] s4_off1;
  logic signed [bptc_pkg::WIDE_W-1:0] s4_sens1;
  logic        [bptc_pkg::D_W-1:0]    s4_d1;

  // Combinational terms.
  logic signed [bptc_pkg::DT_W-1:0]   dt_next;
  logic signed [41:0]                 off_bias;
  logic signed [41:0]                 sens_bias;
  logic signed [41:0]                 t_bias;
  logic signed [bptc_pkg::TEMP_W-1:0] q_next;
  logic                               cold_next;
  logic                               vcold_next;
  logic signed [bptc_pkg::TEMP_W-1:0] temp_fin_next;
  logic        [bptc_pkg::WIDE_W-1:0] sa;
  logic        [bptc_pkg::WIDE_W-1:0] sb;
  logic        [bptc_pkg::WIDE_W-1:0] five_a;
  logic        [bptc_pkg::WIDE_W-1:0] seven_b;
  logic        [bptc_pkg::WIDE_W-1:0] eleven_b;
  logic        [bptc_pkg::WIDE_W-1:0] off2_next;
  logic        [bptc_pkg::WIDE_W-1:0] sens2_next;

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    adv[N-1] = !v[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[N-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // Stage 1: temperature difference dT = D2 - C5*256.
  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, calib.c5, 8'd0});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_dt <= dt_next;
      s1_d1 <= raw_pressure;
    end
  end

  // Stage 2: the four products of dT.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_p_off  <= s1_dt * $signed({1'b0, calib.c4});
      s2_p_sens <= s1_dt * $signed({1'b0, calib.c3});
      s2_p_t    <= s1_dt * $signed({1'b0, calib.c6});
      s2_p_dd   <= s1_dt * s1_dt;
      s2_d1     <= s1_d1;
    end
  end

  // Stage 3: divisions toward zero and first-order sums.
  assign off_bias  = s2_p_off + $signed({35'd0, {7{s2_p_off[41]}}});
  assign sens_bias = s2_p_sens + $signed({34'd0, {8{s2_p_sens[41]}}});
  assign t_bias    = s2_p_t + $signed({19'd0, {23{s2_p_t[41]}}});
  assign q_next    = $signed(t_bias[41:23]);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_off1  <= $signed({8'd0, calib.c2, 16'd0}) +
                  bptc_pkg::WIDE_W'($signed(off_bias[41:7]));
      s3_sens1 <= $signed({9'd0, calib.c1, 15'd0}) +
                  bptc_pkg::WIDE_W'($signed(sens_bias[41:8]));
      s3_q     <= q_next;
      s3_temp  <= q_next + bptc_pkg::TEMP_W'(bptc_pkg::TEMP_REF);
      s3_bq    <= q_next + bptc_pkg::TEMP_W'(bptc_pkg::VCOLD_OFS);
      s3_dd    <= s2_p_dd[49:31];
      s3_d1    <= s2_d1;
    end
  end

  // Stage 4: squares of the temperature offsets and the final temperature.
  assign cold_next     = calib.second_order_enable && s3_q[bptc_pkg::TEMP_W-1];
  assign vcold_next    = calib.second_order_enable && s3_bq[bptc_pkg::TEMP_W-1];
  assign temp_fin_next = cold_next ? s3_temp - $signed(s3_dd) : s3_temp;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_sq_a  <= s3_q * s3_q;
      s4_sq_b  <= s3_bq * s3_bq;
      s4_cold  <= cold_next;
      s4_vcold <= vcold_next;
      s4_temp  <= temp_fin_next;
      s4_off1  <= s3_off1;
      s4_sens1 <= s3_sens1;
      s4_d1    <= s3_d1;
    end
  end

  // Stage 5: cold and very-cold corrections by shift and add.
  assign sa       = {4'd0, s4_sq_a[35:0]};
  assign sb       = {4'd0, s4_sq_b[35:0]};
  assign five_a   = {sa[37:0], 2'b00} + sa;
  assign seven_b  = {sb[36:0], 3'b000} - sb;
  assign eleven_b = {sb[36:0], 3'b000} + {sb[38:0], 1'b0} + sb;

  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    if (s4_cold) begin
      off2_next  = {1'b0, five_a[bptc_pkg::WIDE_W-1:1]};
      sens2_next = {2'b00, five_a[bptc_pkg::WIDE_W-1:2]};
      if (s4_vcold) begin
        off2_next  = off2_next + seven_b;
        sens2_next = sens2_next + {1'b0, eleven_b[bptc_pkg::WIDE_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      corr.d1    <= s4_d1;
      corr.off1  <= s4_off1;
      corr.sens1 <= s4_sens1;
      corr.off2  <= off2_next;
      corr.sens2 <= sens2_next;
      corr.temp  <= s4_temp;
    end
  end

  // A very-cold correction only ever comes with the cold one.
  assert property (@(posedge clk) disable iff (rst) v[3] |-> (!s4_vcold || s4_cold))
    else $error("very-cold correction without cold correction");

  // The sensitivity correction never exceeds the offset correction.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (corr.sens2 <= corr.off2))
    else $error("sensitivity correction exceeds offset correction");

  // Both corrections are zero together or nonzero together.
  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> ((corr.off2 == '0) == (corr.sens2 == '0)))
    else $error("offset and sensitivity corrections disagree");

endmodule

[src/bptc_pres_path.sv]
// Stages six to ten: final OFF and SENS, D1*SENS in partial products, pressure.
module bptc_pres_path (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bptc_pkg::corr_t                 corr,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [bptc_pkg::PRES_W-1:0] pressure_centimbar,
  output logic signed [bptc_pkg::TEMP_W-1:0] temperature_centideg
);

  localparam int N = 5;

  logic [N-1:0] v;
  logic [N-1:0] adv;

  // Stage registers; the temperature rides along to the output.
  logic signed [bptc_pkg::WIDE_W-1:0] s6_off;
  logic signed [bptc_pkg::WIDE_W-1:0] s6_sens;
  logic        [bptc_pkg::D_W-1:0]    s6_d1;
  logic signed [bptc_pkg::TEMP_W-1:0] s6_temp;
  logic        [47:0]                 s7_pp_lo;
  logic signed [40:0]                 s7_pp_hi;
  logic signed [bptc_pkg::WIDE_W-1:0] s7_off;
  logic signed [bptc_pkg::TEMP_W-1:0] s7_temp;
  logic signed [63:0]                 s8_prod;
  logic signed [bptc_pkg::WIDE_W-1:0] s8_off;
  logic signed [bptc_pkg::TEMP_W-1:0] s8_temp;
  logic signed [43:0]                 s9_x;
  logic signed [bptc_pkg::TEMP_W-1:0] s9_temp;

  // Combinational terms.
  logic signed [63:0] hi_ext;
  logic signed [63:0] prod_bias;
  logic signed [43:0] x_bias;

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    adv[N-1] = !v[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[N-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // Stage 6: apply the second-order corrections.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s6_off  <= corr.off1 - $signed(corr.off2);
      s6_sens <= corr.sens1 - $signed(corr.sens2);
      s6_d1   <= corr.d1;
      s6_temp <= corr.temp;
    end
  end

  // Stage 7: D1 times the low and high parts of SENS.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s7_pp_lo <= s6_d1 * s6_sens[23:0];
      s7_pp_hi <= $signed({1'b0, s6_d1}) * $signed(s6_sens[bptc_pkg::WIDE_W-1:24]);
      s7_off   <= s6_off;
      s7_temp  <= s6_temp;
    end
  end

  // Stage 8: combine the partial products.
  assign hi_ext = 64'(s7_pp_hi);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s8_prod <= $signed({hi_ext[39:0], 24'd0}) + $signed({16'd0, s7_pp_lo});
      s8_off  <= s7_off;
      s8_temp <= s7_temp;
    end
  end

  // Stage 9: D1*SENS/2^21 toward zero, minus OFF.
  assign prod_bias = s8_prod + $signed({43'd0, {21{s8_prod[63]}}});

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s9_x    <= 44'($signed(prod_bias[63:21])) - 44'(s8_off);
      s9_temp <= s8_temp;
    end
  end

  // Stage 10: divide by 2^15 toward zero into the output register.
  assign x_bias = s9_x + $signed({29'd0, {15{s9_x[43]}}});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pressure_centimbar   <= bptc_pkg::PRES_W'($signed(x_bias[43:15]));
      temperature_centideg <= s9_temp;
    end
  end

  // Input backpressure only comes from a stalled, full output.
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // A result that was not taken is still offered next cycle.
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // An empty pipeline always takes a transaction.
  assert property (@(posedge clk) disable iff (rst) (v == '0) |-> in_ready)
    else $error("empty pipeline not ready");

endmodule
